FILE: rtl/moving_average_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// moving average filter unit: assertion macros
// shared concurrent assertion forms, clocked on clk_i; only MAF_ASSERT is disabled by rst_ni
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH

// property checked only while out of reset
`define MAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define MAF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// shared types and constants of the moving average filter unit
// ----------------------------------------------------------------------------
package maf_pkg;

  // width of the window length field of the configuration channel
  localparam int unsigned CfgW = 7;
  // window length after reset, before clamping
  localparam int unsigned WindowReset = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DELIVER
  } maf_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_sample;
    logic update;
    logic cfg_write;
    logic out_load;
  } maf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } maf_status_t;

endpackage

FILE: rtl/maf_if.sv
// ----------------------------------------------------------------------------
// maf_if
// valid/ready channels of the moving average filter unit
// ----------------------------------------------------------------------------
interface maf_sample_if #(
  parameter int unsigned W = 10
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface maf_average_if #(
  parameter int unsigned W = 10
);
  logic         valid;
  logic         ready;
  logic [W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

interface maf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [maf_pkg::CfgW-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

FILE: rtl/maf_divider.sv
// ----------------------------------------------------------------------------
// maf_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module maf_divider #(
  parameter int unsigned DIVIDEND_W = 16,
  parameter int unsigned DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    done_d = busy_q && (cnt_q == CntW'(1));
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DIVIDEND_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIVISOR_W'(trial - {1'b0, div_q}) : DIVISOR_W'(trial);
      quo_d = DIVIDEND_W'({quo_q, ge});
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/maf_datapath.sv
// ----------------------------------------------------------------------------
// maf_datapath
// ring store, running total, write index, window register and divider
// ----------------------------------------------------------------------------
`include "moving_average_filter_unit_macros.svh"

module maf_datapath #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  maf_pkg::maf_cmd_t          cmd_i,
  output maf_pkg::maf_status_t       status_o,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  logic [maf_pkg::CfgW-1:0]   cfg_data_i,
  output logic [SAMPLE_BITS-1:0]     average_o
);

  import maf_pkg::*;

  localparam int unsigned IdxW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WinW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TotalW = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned WinResetClamped =
    (WindowReset < 1) ? 1 : ((WindowReset > MAX_WINDOW) ? MAX_WINDOW : WindowReset);

  logic [SAMPLE_BITS-1:0] mem_q [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] average_q;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [WinW-1:0]   fill_q, fill_d;
  logic [WinW-1:0]   win_q, win_d;
  logic [TotalW-1:0] total_q, total_d;

  logic [WinW-1:0]        idx_inc;
  logic [WinW-1:0]        win_cfg;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [TotalW-1:0]      quotient;
  logic                   div_done;

  // clamp the written window length into 1..MAX_WINDOW
  always_comb begin
    if (cfg_data_i == '0) begin
      win_cfg = WinW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_WINDOW)) begin
      win_cfg = WinW'(MAX_WINDOW);
    end else begin
      win_cfg = WinW'(cfg_data_i);
    end
  end

  // entries at or beyond the fill count were never written since the last clear
  assign old_sample = (WinW'(idx_q) < fill_q) ? rd_q : '0;
  assign idx_inc    = WinW'(idx_q) + WinW'(1);

  always_comb begin
    idx_d   = idx_q;
    fill_d  = fill_q;
    win_d   = win_q;
    total_d = total_q - TotalW'(old_sample) + TotalW'(sample_q);
    if (cmd_i.cfg_write) begin
      win_d  = win_cfg;
      idx_d  = '0;
      fill_d = '0;
    end else if (cmd_i.update) begin
      idx_d  = (idx_inc >= win_q) ? '0 : IdxW'(idx_inc);
      fill_d = (fill_q < win_q) ? fill_q + WinW'(1) : fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      fill_q  <= '0;
      win_q   <= WinW'(WinResetClamped);
      total_q <= '0;
    end else begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
      win_q  <= win_d;
      if (cmd_i.cfg_write) begin
        total_q <= '0;
      end else if (cmd_i.update) begin
        total_q <= total_d;
      end
    end
  end

  // ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem_q[idx_q] <= sample_q;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_i;
    end
    if (cmd_i.out_load) begin
      average_q <= SAMPLE_BITS'(quotient);
    end
  end

  maf_divider #(
    .DIVIDEND_W (TotalW),
    .DIVISOR_W  (WinW)
  ) u_maf_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.update),
    .dividend_i (total_d),
    .divisor_i  (win_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.div_done = div_done;
  assign average_o         = average_q;

  `MAF_ASSERT(a_idx_in_window, WinW'(idx_q) < win_q, "write index outside window")
  `MAF_ASSERT(a_fill_in_window, fill_q <= win_q, "fill count above window length")

endmodule

FILE: rtl/maf_ctrl.sv
// ----------------------------------------------------------------------------
// maf_ctrl
// sequencer for one sample: update, divide, deliver
// ----------------------------------------------------------------------------
`include "moving_average_filter_unit_macros.svh"

module maf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  maf_pkg::maf_status_t  status_i,
  output maf_pkg::maf_cmd_t     cmd_o
);

  import maf_pkg::*;

  maf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        // a window length beat goes first, the sample waits while one is offered
        in_ready_o      = !cfg_valid_i;
        cfg_ready_o     = 1'b1;
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `MAF_ASSERT_ALWAYS(a_done_in_divide, status_i.div_done |-> state_q == ST_DIVIDE,
                     "divider done outside divide")
  `MAF_ASSERT(a_load_slot_free, cmd_o.out_load |-> (!out_valid_q || out_ready_i),
              "result overwrites pending beat")

endmodule

FILE: rtl/moving_average_filter_unit.sv
// ----------------------------------------------------------------------------
// moving_average_filter_unit
// moving average over the last window_length samples, ring store based
// ----------------------------------------------------------------------------
// Each sample beat replaces the oldest entry of a ring store, updates a running
// total and returns total / window_length, truncated. Writing window_length
// (clamped to 1..MAX_WINDOW, zero reads as one) clears total, index and fill
// count, so entries not written since then read as zero and early averages
// count zeros. The quotient comes from a bit-serial divider, which produces one
// quotient bit per cycle; no new sample is accepted until the average of the
// last one is in the output register. A finished average waits there, so the
// next sample is accepted while it is still pending. Configuration beats are
// taken only while no sample is in work.
// ----------------------------------------------------------------------------
module moving_average_filter_unit #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  maf_sample_if.sink          sample_if_i,
  maf_cfg_if.sink             cfg_if_i,
  maf_average_if.source       average_if_o
);

  import maf_pkg::*;

  // command and status between sequencer and datapath
  maf_cmd_t    cmd;
  maf_status_t status;

  // sequencer: handshakes and step order
  maf_ctrl u_maf_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_if_i.valid),
    .in_ready_o  (sample_if_i.ready),
    .cfg_valid_i (cfg_if_i.valid),
    .cfg_ready_o (cfg_if_i.ready),
    .out_valid_o (average_if_o.valid),
    .out_ready_i (average_if_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: ring store, running total, window register, divider
  maf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_maf_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .sample_i   (sample_if_i.sample),
    .cfg_data_i (cfg_if_i.window_length),
    .average_o  (average_if_o.average)
  );

endmodule
